@@ src/chb_pkg.sv @@
package chb_pkg;

   localparam int SYM_W    = 8;
   localparam int IDX_W    = 8;
   localparam int SIZE_W   = 9;
   localparam int LEN_W    = 6;
   localparam int CODE_W   = 32;
   localparam int WEIGHT_W = 40;
   localparam int TAB_W    = 8;
   localparam int TAB_DEPTH = 256;
   localparam int CMP_W    = 16;

   typedef enum logic [1:0] {
      CMD_COUNT = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_IDX  = 2'd1,
      STAT_LONG = 2'd2
   } stat_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_CLR, ST_RD_A, ST_RD_B,
      ST_SCAN_RD, ST_SCAN_EV, ST_SCAN_END,
      ST_MRG_INIT, ST_MRG_RD, ST_MRG_EV, ST_MRG_W1, ST_MRG_W2, ST_MRG_W3,
      ST_DEP_INIT, ST_DEP_RP, ST_DEP_RD, ST_DEP_WR, ST_DEP_END,
      ST_CAN_INIT, ST_CAN_RD, ST_CAN_EV, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CNT_WR, OP_CLR,
      OP_SCAN_RD, OP_SCAN_EV, OP_SCAN_END,
      OP_MRG_INIT, OP_MRG_EV, OP_MRG_W1, OP_MRG_W2, OP_MRG_W3,
      OP_DEP_INIT, OP_DEP_WR,
      OP_CAN_INIT, OP_CAN_RD, OP_CAN_EV
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rsp_ld;
   } ctrl_type;

   typedef struct packed {
      logic scan_last;
      logic n_zero;
      logic n_one;
      logic mrg_scan_last;
      logic mrg_last;
      logic dep_last;
      logic build_err;
      logic can_done;
   } stat_flags_type;

endpackage

@@ src/canonical_huffman_table_builder.sv @@
// count steps through CNT_RD and CNT_WR, clear through CLR, read through RD_A and RD_B,
// build through the scan, merge, depth and canonical states to DONE; the result strobe is
//   registered after the last of these; a build spends most of its time in the lightest-pair scan
// one item at a time: busy is high from accept until the result strobe
// synchronous active-high reset clears histogram valid bits, table size and error flag
// the result strobe lasts one cycle; the receiver cannot stall
module canonical_huffman_table_builder #(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_BITS    = 32,
   parameter int MAX_CODE_LEN  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [chb_pkg::SYM_W-1:0]     req_symbol,
   input  logic [chb_pkg::IDX_W-1:0]     req_entry_index,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [chb_pkg::SIZE_W-1:0]    rsp_entry_count,
   output logic [chb_pkg::SYM_W-1:0]     rsp_out_symbol,
   output logic [chb_pkg::LEN_W-1:0]     rsp_code_length,
   output logic [chb_pkg::CODE_W-1:0]    rsp_code_value
);
   import chb_pkg::*;

   ctrl_type       ctrl;
   stat_flags_type flags;
   cmd_type        cmd;

   assign cmd = cmd_type'(req_cmd);

   chb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (cmd),
      .flags   (flags),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   chb_dp #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_BITS    (COUNT_BITS),
      .MAX_CODE_LEN  (MAX_CODE_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (cmd),
      .req_symbol      (req_symbol),
      .req_entry_index (req_entry_index),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_code_length (rsp_code_length),
      .rsp_code_value  (rsp_code_value)
   );

endmodule

@@ src/chb_ctrl.sv @@
module chb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  chb_pkg::cmd_type        req_cmd,
   input  chb_pkg::stat_flags_type flags,
   output chb_pkg::ctrl_type       ctrl,
   output logic                    busy
);
   import chb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_COUNT: state_in = ST_CNT_RD;
                  CMD_BUILD: state_in = ST_SCAN_RD;
                  CMD_READ:  state_in = ST_RD_A;
                  default:   state_in = ST_CLR;
               endcase
            end
         end
         ST_CNT_RD:   state_in = ST_CNT_WR;
         ST_CNT_WR:   state_in = ST_IDLE;
         ST_CLR:      state_in = ST_IDLE;
         ST_RD_A:     state_in = ST_RD_B;
         ST_RD_B:     state_in = ST_IDLE;
         ST_SCAN_RD:  state_in = ST_SCAN_EV;
         ST_SCAN_EV:  state_in = flags.scan_last ? ST_SCAN_END : ST_SCAN_RD;
         ST_SCAN_END: state_in = (flags.n_zero || flags.n_one) ? ST_DONE : ST_MRG_INIT;
         ST_MRG_INIT: state_in = ST_MRG_RD;
         ST_MRG_RD:   state_in = ST_MRG_EV;
         ST_MRG_EV:   state_in = flags.mrg_scan_last ? ST_MRG_W1 : ST_MRG_RD;
         ST_MRG_W1:   state_in = ST_MRG_W2;
         ST_MRG_W2:   state_in = ST_MRG_W3;
         ST_MRG_W3:   state_in = flags.mrg_last ? ST_DEP_INIT : ST_MRG_INIT;
         ST_DEP_INIT: state_in = ST_DEP_RP;
         ST_DEP_RP:   state_in = ST_DEP_RD;
         ST_DEP_RD:   state_in = ST_DEP_WR;
         ST_DEP_WR:   state_in = flags.dep_last ? ST_DEP_END : ST_DEP_RP;
         ST_DEP_END:  state_in = flags.build_err ? ST_DONE : ST_CAN_INIT;
         ST_CAN_INIT: state_in = ST_CAN_RD;
         ST_CAN_RD:   state_in = ST_CAN_EV;
         ST_CAN_EV:   state_in = flags.can_done ? ST_DONE : ST_CAN_RD;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.op     = OP_NONE;
      ctrl.rsp_ld = 1'b0;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) ctrl.op = OP_LOAD;
         end
         ST_CNT_WR: begin
            ctrl.op     = OP_CNT_WR;
            ctrl.rsp_ld = 1'b1;
         end
         ST_CLR: begin
            ctrl.op     = OP_CLR;
            ctrl.rsp_ld = 1'b1;
         end
         ST_RD_B:     ctrl.rsp_ld = 1'b1;
         ST_SCAN_RD:  ctrl.op = OP_SCAN_RD;
         ST_SCAN_EV:  ctrl.op = OP_SCAN_EV;
         ST_SCAN_END: ctrl.op = OP_SCAN_END;
         ST_MRG_INIT: ctrl.op = OP_MRG_INIT;
         ST_MRG_EV:   ctrl.op = OP_MRG_EV;
         ST_MRG_W1:   ctrl.op = OP_MRG_W1;
         ST_MRG_W2:   ctrl.op = OP_MRG_W2;
         ST_MRG_W3:   ctrl.op = OP_MRG_W3;
         ST_DEP_INIT: ctrl.op = OP_DEP_INIT;
         ST_DEP_WR:   ctrl.op = OP_DEP_WR;
         ST_CAN_INIT: ctrl.op = OP_CAN_INIT;
         ST_CAN_RD:   ctrl.op = OP_CAN_RD;
         ST_CAN_EV:   ctrl.op = OP_CAN_EV;
         ST_DONE:     ctrl.rsp_ld = 1'b1;
         default:     ctrl.op = OP_NONE;
      endcase
   end

endmodule

@@ src/chb_dp.sv @@
module chb_dp #(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_BITS    = 32,
   parameter int MAX_CODE_LEN  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chb_pkg::ctrl_type             ctrl,
   input  chb_pkg::cmd_type              req_cmd,
   input  logic [chb_pkg::SYM_W-1:0]     req_symbol,
   input  logic [chb_pkg::IDX_W-1:0]     req_entry_index,
   output chb_pkg::stat_flags_type       flags,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [chb_pkg::SIZE_W-1:0]    rsp_entry_count,
   output logic [chb_pkg::SYM_W-1:0]     rsp_out_symbol,
   output logic [chb_pkg::LEN_W-1:0]     rsp_code_length,
   output logic [chb_pkg::CODE_W-1:0]    rsp_code_value
);
   import chb_pkg::*;

   localparam int NODES  = 2 * ALPHABET_SIZE - 1;
   localparam int NODE_W = $clog2(NODES);
   localparam int HIST_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ENT_W  = SYM_W + LEN_W + CODE_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // request registers
   cmd_type            cmd_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [IDX_W-1:0]   idx_ff;

   // stores
   logic [COUNT_BITS-1:0] hist_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] hist_vld_ff;
   logic [WEIGHT_W-1:0]   weight_mem [NODES];
   logic                  live_mem [NODES];
   logic [NODE_W-1:0]     parent_mem [NODES];
   logic [NODE_W-1:0]     depth_mem [NODES];
   logic [SYM_W-1:0]      leaf_mem [ALPHABET_SIZE];
   logic [ENT_W-1:0]      table_mem [TAB_DEPTH];

   logic [COUNT_BITS-1:0] hist_rd_ff;
   logic                  hist_vrd_ff;
   logic [WEIGHT_W-1:0]   weight_rd_ff;
   logic                  live_rd_ff;
   logic [NODE_W-1:0]     parent_rd_ff;
   logic [NODE_W-1:0]     depth_rd_ff;
   logic [SYM_W-1:0]      leaf_rd_ff;
   logic [ENT_W-1:0]      table_rd_ff;

   // counters and working registers
   logic [HIST_W-1:0]   i_ff;
   logic [NODE_W-1:0]   n_ff, j_ff, total_ff, c_ff;
   logic [SIZE_W-1:0]   k_ff;
   logic [LEN_W-1:0]    len_ff, prev_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [WEIGHT_W-1:0] w1_ff, w2_ff;
   logic [NODE_W-1:0]   a_ff, b_ff;
   logic                f1_ff, f2_ff;
   logic [SYM_W-1:0]    first_sym_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                err_ff;

   logic [HIST_W-1:0]   hist_addr;
   logic                sym_ok;
   logic                hist_nz;
   logic [WEIGHT_W:0]   wsum;
   logic [WEIGHT_W-1:0] wsat;
   logic [NODE_W-1:0]   cm1;
   logic [NODE_W-1:0]   depth_addr;
   logic [NODE_W-1:0]   dep_new;
   logic                can_match;
   logic [CODE_W:0]     code_inc;
   logic [CODE_W:0]     code_sh;
   logic [CODE_W-1:0]   code_new;
   logic [LEN_W-1:0]    len_diff;
   logic [1:0]          stat_c;

   assign sym_ok    = {1'b0, sym_ff} < (SYM_W + 1)'(ALPHABET_SIZE);
   assign hist_addr = (ctrl.op == OP_SCAN_RD) ? i_ff : sym_ff[HIST_W-1:0];
   assign hist_nz   = hist_vrd_ff && (hist_rd_ff != '0);
   assign wsum      = {1'b0, w1_ff} + {1'b0, w2_ff};
   assign wsat      = wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];
   assign cm1       = c_ff - 1'b1;
   assign depth_addr = (ctrl.op == OP_CAN_RD) ? j_ff : parent_rd_ff;
   assign dep_new   = depth_rd_ff + 1'b1;
   assign can_match = CMP_W'(depth_rd_ff) == CMP_W'(len_ff);
   assign code_inc  = {1'b0, code_ff} + 1'b1;
   assign len_diff  = len_ff - prev_ff;
   assign code_sh   = code_inc << len_diff;
   assign code_new  = (k_ff == '0) ? '0 : code_sh[CODE_W-1:0];

   assign flags.scan_last     = i_ff == HIST_W'(ALPHABET_SIZE - 1);
   assign flags.n_zero        = n_ff == '0;
   assign flags.n_one         = n_ff == NODE_W'(1);
   assign flags.mrg_scan_last = j_ff == total_ff - 1'b1;
   assign flags.mrg_last      = ({1'b0, total_ff} + 1'b1) == ({n_ff, 1'b0} - 1'b1);
   assign flags.dep_last      = c_ff == NODE_W'(1);
   assign flags.build_err     = err_ff;
   assign flags.can_done      = can_match && (k_ff + 1'b1 == SIZE_W'(n_ff));

   // request latch
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_LOAD) begin
         cmd_ff <= req_cmd;
         sym_ff <= req_symbol;
         idx_ff <= req_entry_index;
      end
   end

   // histogram
   always_ff @(posedge clock) begin
      hist_rd_ff  <= hist_mem[hist_addr];
      hist_vrd_ff <= hist_vld_ff[hist_addr];
      if (ctrl.op == OP_CNT_WR && sym_ok && !(hist_vrd_ff && hist_rd_ff == COUNT_MAX)) begin
         hist_mem[hist_addr] <= hist_vrd_ff ? hist_rd_ff + 1'b1 : COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.op == OP_CLR) begin
         hist_vld_ff <= '0;
      end else if (ctrl.op == OP_CNT_WR && sym_ok) begin
         hist_vld_ff[hist_addr] <= 1'b1;
      end
   end

   // tree stores
   always_ff @(posedge clock) begin
      weight_rd_ff <= weight_mem[j_ff];
      if (ctrl.op == OP_SCAN_EV && hist_nz) begin
         weight_mem[n_ff] <= WEIGHT_W'(hist_rd_ff);
      end else if (ctrl.op == OP_MRG_W1) begin
         weight_mem[total_ff] <= wsat;
      end
   end

   always_ff @(posedge clock) begin
      live_rd_ff <= live_mem[j_ff];
      case (ctrl.op)
         OP_SCAN_EV: if (hist_nz) live_mem[n_ff] <= 1'b1;
         OP_MRG_W1:  live_mem[a_ff] <= 1'b0;
         OP_MRG_W2:  live_mem[b_ff] <= 1'b0;
         OP_MRG_W3:  live_mem[total_ff] <= 1'b1;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      parent_rd_ff <= parent_mem[cm1];
      if (ctrl.op == OP_MRG_W1) begin
         parent_mem[a_ff] <= total_ff;
      end else if (ctrl.op == OP_MRG_W2) begin
         parent_mem[b_ff] <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      depth_rd_ff <= depth_mem[depth_addr];
      if (ctrl.op == OP_DEP_INIT) begin
         depth_mem[total_ff - 1'b1] <= '0;
      end else if (ctrl.op == OP_DEP_WR) begin
         depth_mem[cm1] <= dep_new;
      end
   end

   always_ff @(posedge clock) begin
      leaf_rd_ff <= leaf_mem[j_ff[HIST_W-1:0]];
      if (ctrl.op == OP_SCAN_EV && hist_nz) begin
         leaf_mem[n_ff[HIST_W-1:0]] <= SYM_W'(i_ff);
      end
   end

   always_ff @(posedge clock) begin
      table_rd_ff <= table_mem[idx_ff];
      if (ctrl.op == OP_SCAN_END && flags.n_one) begin
         table_mem[TAB_W'(0)] <= {first_sym_ff, LEN_W'(1), CODE_W'(0)};
      end else if (ctrl.op == OP_CAN_EV && can_match) begin
         table_mem[k_ff[TAB_W-1:0]] <= {leaf_rd_ff, len_ff, code_new};
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LOAD: begin
            i_ff <= '0;
            n_ff <= '0;
         end
         OP_SCAN_EV: begin
            i_ff <= i_ff + 1'b1;
            if (hist_nz) begin
               n_ff <= n_ff + 1'b1;
               if (n_ff == '0) first_sym_ff <= SYM_W'(i_ff);
            end
         end
         OP_SCAN_END: total_ff <= n_ff;
         OP_MRG_INIT: begin
            j_ff  <= '0;
            f1_ff <= 1'b0;
            f2_ff <= 1'b0;
         end
         OP_MRG_EV: begin
            j_ff <= j_ff + 1'b1;
            if (live_rd_ff) begin
               if (!f1_ff || weight_rd_ff < w1_ff) begin
                  w2_ff <= w1_ff;
                  b_ff  <= a_ff;
                  f2_ff <= f1_ff;
                  w1_ff <= weight_rd_ff;
                  a_ff  <= j_ff;
                  f1_ff <= 1'b1;
               end else if (!f2_ff || weight_rd_ff < w2_ff) begin
                  w2_ff <= weight_rd_ff;
                  b_ff  <= j_ff;
                  f2_ff <= 1'b1;
               end
            end
         end
         OP_MRG_W3:   total_ff <= total_ff + 1'b1;
         OP_DEP_INIT: c_ff <= total_ff - 1'b1;
         OP_DEP_WR:   c_ff <= cm1;
         OP_CAN_INIT: begin
            j_ff    <= '0;
            k_ff    <= '0;
            len_ff  <= LEN_W'(1);
            prev_ff <= '0;
            code_ff <= '0;
         end
         OP_CAN_EV: begin
            if (can_match) begin
               code_ff <= code_new;
               prev_ff <= len_ff;
               k_ff    <= k_ff + 1'b1;
            end
            if (j_ff == n_ff - 1'b1) begin
               j_ff   <= '0;
               len_ff <= len_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         err_ff  <= 1'b0;
      end else if (ctrl.op == OP_SCAN_END) begin
         size_ff <= SIZE_W'(n_ff);
         err_ff  <= 1'b0;
      end else if (ctrl.op == OP_DEP_WR && cm1 < n_ff &&
                   CMP_W'(dep_new) > CMP_W'(MAX_CODE_LEN)) begin
         err_ff <= 1'b1;
      end
   end

   // result
   always_comb begin
      stat_c = STAT_OK;
      case (cmd_ff)
         CMD_READ: begin
            if ({1'b0, idx_ff} >= size_ff) stat_c = STAT_IDX;
            else if (err_ff)               stat_c = STAT_LONG;
         end
         CMD_BUILD: if (err_ff) stat_c = STAT_LONG;
         default:   stat_c = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.rsp_ld;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_ld) begin
         rsp_status      <= stat_c;
         rsp_entry_count <= size_ff;
         if (cmd_ff == CMD_READ && stat_c == STAT_OK) begin
            {rsp_out_symbol, rsp_code_length, rsp_code_value} <= table_rd_ff;
         end else begin
            rsp_out_symbol  <= '0;
            rsp_code_length <= '0;
            rsp_code_value  <= '0;
         end
      end
   end

endmodule

@@ src/chb_chk.sv @@
module chb_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_out_symbol,
   input logic [5:0]  rsp_code_length,
   input logic [31:0] rsp_code_value
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results without an item between");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("undefined status code");

   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'd0 |->
         rsp_out_symbol == '0 && rsp_code_length == '0 && rsp_code_value == '0)
      else $error("entry fields set on a failed item");

endmodule

bind canonical_huffman_table_builder chb_chk u_chb_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_out_symbol  (rsp_out_symbol),
   .rsp_code_length (rsp_code_length),
   .rsp_code_value  (rsp_code_value)
);
